// ----- design/pit_pkg.sv -----
// Package for the process identifier table: field widths, action and status
// codes, the stored record layout and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package pit_pkg;

    localparam int TABLE_SLOTS_DEF = 32;

    localparam int ACT_W     = 2;
    localparam int ID_W      = 32;
    localparam int PSTATE_W  = 3;
    localparam int STATUS_W  = 3;
    localparam int LCOUNT_W  = 6;

    // stream widths; the tdata widths are padded to whole bytes
    localparam int IN_TDATA_W  = 200;
    localparam int IN_TUSER_W  = ACT_W;
    localparam int OUT_TDATA_W = 176;
    localparam int OUT_TUSER_W = STATUS_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_REGISTER  = 2'd0,
        ACT_SET_STATE = 2'd1,
        ACT_SET_EXIT  = 2'd2,
        ACT_FIND      = 2'd3
    } t_act;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    localparam logic [PSTATE_W-1:0] PSTATE_FREE    = 3'd0;
    localparam logic [PSTATE_W-1:0] PSTATE_CREATED = 3'd1;

    // one table row
    typedef struct packed {
        logic [ID_W-1:0]     exit_val;
        logic [PSTATE_W-1:0] pstate;
        logic [ID_W-1:0]     group_ident;
        logic [ID_W-1:0]     user_ident;
        logic [ID_W-1:0]     domain_ident;
        logic [ID_W-1:0]     parent_id;
        logic [ID_W-1:0]     proc_id;
    } t_rec;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_fsm;

endpackage

// ----- design/process_id_table.sv -----
// Process identifier table: top level with the row memory, the scan sequencer
// and the result register. Depends on pit_pkg.
`timescale 1ns / 1ps

// A table of TABLE_SLOTS process records keyed by a nonzero 32-bit identifier.
// Each input item carries an action in tuser (register, set state, set exit
// code, find) and returns exactly one result item whose tuser is the status.
// The rows live in a simple dual-port memory (one read and one write a
// cycle); one identifier comparator walks the rows one per cycle. An item
// goes through acceptance, the scan with its registered memory reads, and a
// finish step that writes back any changed row and loads the result. The
// scan stops early at the first live match (or, for register, at the first
// row with the same identifier). An identifier of zero, or a register while
// the count is at capacity, skips the scan and goes straight to the finish
// step. The input is not ready while an item is in work. A result sits in an
// output register, so the next item may be accepted while it waits. After
// reset a clearing pass zeroes every row before the first item is taken.
module process_id_table
    import pit_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: proc_id, parent_id, domain_ident, user_ident, group_ident,
    //        new_state, new exit code, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: action
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: hit, found_parent, found_domain, found_user, found_group,
    //        found_state, found exit code, live_count, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    // row memory
    t_rec r_mem [TABLE_SLOTS];
    t_rec r_rd_data;

    // sequencer
    t_fsm             r_state, n_state;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    // item being worked on
    t_act                r_act;
    logic [ID_W-1:0]     r_id;
    logic [ID_W-1:0]     r_parent;
    logic [ID_W-1:0]     r_domain;
    logic [ID_W-1:0]     r_user;
    logic [ID_W-1:0]     r_group;
    logic [PSTATE_W-1:0] r_nstate;
    logic [ID_W-1:0]     r_nexit;

    // scan findings
    logic             r_dup;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    t_rec             r_hit_rec;

    logic [CNT_W-1:0] r_cnt, n_cnt;

    // result register
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    t_status                r_out_user;

    // combinational control
    logic             accept;
    logic             skip_scan;
    logic             issue;
    logic             id_match;
    logic             slot_free;
    logic             live_match;
    logic             scan_stop;
    logic             out_free;
    logic             fin_go;
    t_status          fin_status;
    logic             fin_we;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_rec             mem_wd;
    t_rec             fin_rec;
    logic [IDX_W-1:0] rd_addr;
    logic             found;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = o_s_axis_tready && i_s_axis_tvalid;
    assign out_free        = !r_out_vld || i_m_axis_tready;

    // zero identifier and a register at full count need no scan
    assign skip_scan = (i_s_axis_tdata[ID_W-1:0] == '0)
                    || ((t_act'(i_s_axis_tuser[ACT_W-1:0]) == ACT_REGISTER)
                        && (r_cnt >= SLOTS_C));

    assign issue   = (r_state == S_SCAN) && (r_idx < SLOTS_C);
    assign rd_addr = r_idx[IDX_W-1:0];

    // the shared comparator: one row a cycle
    assign id_match   = r_rd_vld && (r_rd_data.proc_id == r_id);
    assign slot_free  = (r_rd_data.pstate == PSTATE_FREE);
    assign live_match = id_match && !slot_free;
    assign scan_stop  = r_rd_vld
                     && (((r_act == ACT_REGISTER) ? id_match : live_match)
                         || (r_rd_idx == LAST_IDX));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx[IDX_W-1:0] == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = skip_scan ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_stop) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // status of the finished item, checks in priority order
    always_comb begin
        fin_status = ST_OK;
        if (r_id == '0) begin
            fin_status = ST_INVALID;
        end else if (r_act == ACT_REGISTER) begin
            if (r_cnt >= SLOTS_C) begin
                fin_status = ST_FULL;
            end else if (r_dup) begin
                fin_status = ST_EXISTS;
            end else if (!r_free_ok) begin
                fin_status = ST_FULL;
            end
        end else if (!r_hit) begin
            fin_status = ST_NOT_FOUND;
        end
    end

    assign fin_go = (r_state == S_FIN) && out_free;
    assign fin_we = fin_go && (fin_status == ST_OK) && (r_act != ACT_FIND);
    assign found  = (r_act == ACT_FIND) && (fin_status == ST_OK);
    assign n_cnt  = (fin_go && (fin_status == ST_OK) && (r_act == ACT_REGISTER))
                  ? r_cnt + CNT_W'(1) : r_cnt;

    // row written back by the finished item
    always_comb begin
        fin_rec = r_hit_rec;
        case (r_act)
            ACT_REGISTER: begin
                fin_rec.proc_id      = r_id;
                fin_rec.parent_id    = r_parent;
                fin_rec.domain_ident = r_domain;
                fin_rec.user_ident   = r_user;
                fin_rec.group_ident  = r_group;
                fin_rec.pstate       = PSTATE_CREATED;
                fin_rec.exit_val     = '0;
            end
            ACT_SET_STATE: fin_rec.pstate   = r_nstate;
            ACT_SET_EXIT:  fin_rec.exit_val = r_nexit;
            default:       fin_rec = r_hit_rec;
        endcase
    end

    // memory write port: clearing pass or writeback
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx[IDX_W-1:0];
        mem_wd = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (fin_we) begin
            mem_we = 1'b1;
            mem_wa = (r_act == ACT_REGISTER) ? r_free_idx : r_hit_idx;
            mem_wd = fin_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    // row counter and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_rd_vld <= issue;
            r_cnt    <= n_cnt;
            if (accept) begin
                r_idx <= '0;
            end else if ((r_state == S_CLEAR) || issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
    end

    // capture the item; clear findings for the new scan
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act    <= t_act'(i_s_axis_tuser[ACT_W-1:0]);
            r_id     <= i_s_axis_tdata[31:0];
            r_parent <= i_s_axis_tdata[63:32];
            r_domain <= i_s_axis_tdata[95:64];
            r_user   <= i_s_axis_tdata[127:96];
            r_group  <= i_s_axis_tdata[159:128];
            r_nstate <= i_s_axis_tdata[162:160];
            r_nexit  <= i_s_axis_tdata[194:163];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup     <= 1'b0;
            r_free_ok <= 1'b0;
            r_hit     <= 1'b0;
        end else if (accept) begin
            r_dup     <= 1'b0;
            r_free_ok <= 1'b0;
            r_hit     <= 1'b0;
        end else if ((r_state == S_SCAN) && r_rd_vld) begin
            if (id_match) begin
                r_dup <= 1'b1;
            end
            // keep the first free row
            if (slot_free && !r_free_ok) begin
                r_free_ok <= 1'b1;
            end
            // keep the first live row with this identifier
            if (live_match && !r_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && r_rd_vld) begin
            if (slot_free && !r_free_ok) begin
                r_free_idx <= r_rd_idx;
            end
            if (live_match && !r_hit) begin
                r_hit_idx <= r_rd_idx;
                r_hit_rec <= r_rd_data;
            end
        end
    end

    // result payload: count always, found fields only on a find hit
    always_comb begin
        n_out_data          = '0;
        n_out_data[169:164] = LCOUNT_W'(n_cnt);
        if (found) begin
            n_out_data[0]       = 1'b1;
            n_out_data[32:1]    = r_hit_rec.parent_id;
            n_out_data[64:33]   = r_hit_rec.domain_ident;
            n_out_data[96:65]   = r_hit_rec.user_ident;
            n_out_data[128:97]  = r_hit_rec.group_ident;
            n_out_data[131:129] = r_hit_rec.pstate;
            n_out_data[163:132] = r_hit_rec.exit_val;
        end
    end

    // result register: load on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_go) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_user <= fin_status;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // registration count only grows
    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cnt >= $past(r_cnt)))
        else $error("registration count went down");

    // count never passes the table size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SLOTS_C)
        else $error("registration count beyond table size");

    // a hit is reported only with an ok status
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_data[0]) |-> (r_out_user == ST_OK))
        else $error("hit reported with a failing status");

    // the memory is written only by the clearing pass or a writeback
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_CLEAR) || (r_state == S_FIN)))
        else $error("row memory written outside clear or writeback");

endmodule
